### hdl/pcap_packet_classifier_core_defines.svh
// Assertion macros shared by the classifier RTL.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef PCAP_PACKET_CLASSIFIER_CORE_DEFINES_SVH
`define PCAP_PACKET_CLASSIFIER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define PCAP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PCAP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PCAP_ASSERT_IMP(lbl, ante, cons)
`define PCAP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hdl/pcap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcap_pkg;

	localparam int unsigned GlobalHdrBytes = 24;
	localparam int unsigned RecHdrBytes    = 16;
	localparam int unsigned EthHiPos       = 12;
	localparam int unsigned EthLoPos       = 13;
	localparam int unsigned ProtoPos       = 23;

	localparam logic [1:0] LINK_IPV4  = 2'd0;
	localparam logic [1:0] LINK_ARP   = 2'd1;
	localparam logic [1:0] LINK_IPV6  = 2'd2;
	localparam logic [1:0] LINK_OTHER = 2'd3;

	localparam logic [2:0] TRANS_TCP   = 3'd0;
	localparam logic [2:0] TRANS_UDP   = 3'd1;
	localparam logic [2:0] TRANS_ICMP  = 3'd2;
	localparam logic [2:0] TRANS_IGMP  = 3'd3;
	localparam logic [2:0] TRANS_OTHER = 3'd4;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

	localparam logic [7:0] IPPROTO_ICMP = 8'd1;
	localparam logic [7:0] IPPROTO_IGMP = 8'd2;
	localparam logic [7:0] IPPROTO_TCP  = 8'd6;
	localparam logic [7:0] IPPROTO_UDP  = 8'd17;

	localparam int unsigned NumLink  = 4;
	localparam int unsigned NumTrans = 5;

	typedef struct packed {
		logic        emit;
		logic [1:0]  link;
		logic [2:0]  trans;
		logic [31:0] length;
	} pcap_evt_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage
`default_nettype wire

### hdl/pcap_parse.sv
`timescale 1ns / 1ps
`default_nettype none
module pcap_parse import pcap_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] data_byte,
	output pcap_evt_t       evt
);

	typedef enum logic [2:0] {
		PH_GLOBAL = 3'b001,
		PH_RECHDR = 3'b010,
		PH_FRAME  = 3'b100
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] pos_q, pos_d, pos_inc;
	logic [31:0] clen_q, clen_d;
	logic [7:0]  eth_hi_q, eth_hi_d;
	logic [7:0]  eth_lo_q, eth_lo_d;
	logic [7:0]  proto_q, proto_d;
	logic [2:0]  seen_q, seen_d;
	logic        emit;

	assign pos_inc = pos_q + 32'd1;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_inc;
		clen_d   = clen_q;
		eth_hi_d = eth_hi_q;
		eth_lo_d = eth_lo_q;
		proto_d  = proto_q;
		seen_d   = seen_q;
		emit     = 1'b0;
		case (phase_q)
			PH_RECHDR: begin
				if (pos_q inside {[32'd8:32'd11]}) begin
					case (pos_q[1:0])
						2'd0: clen_d[7:0]   = data_byte;
						2'd1: clen_d[15:8]  = data_byte;
						2'd2: clen_d[23:16] = data_byte;
						default: clen_d[31:24] = data_byte;
					endcase
				end
				if (pos_q == 32'(RecHdrBytes - 1)) begin
					pos_d  = '0;
					seen_d = '0;
					if (clen_q == '0) begin
						emit = 1'b1;
					end else begin
						phase_d = PH_FRAME;
					end
				end
			end
			PH_FRAME: begin
				if (pos_q == 32'(EthHiPos)) begin
					eth_hi_d  = data_byte;
					seen_d[0] = 1'b1;
				end else if (pos_q == 32'(EthLoPos)) begin
					eth_lo_d  = data_byte;
					seen_d[1] = 1'b1;
				end else if (pos_q == 32'(ProtoPos)) begin
					proto_d   = data_byte;
					seen_d[2] = 1'b1;
				end
				// pos + 1 == length marks the last frame byte; length is never zero here.
				if (pos_inc == clen_q) begin
					emit = 1'b1;
				end
			end
			default: begin
				if (pos_q >= 32'(GlobalHdrBytes - 1)) begin
					phase_d = PH_RECHDR;
					pos_d   = '0;
					clen_d  = '0;
				end
			end
		endcase
		if (emit) begin
			phase_d = PH_RECHDR;
			pos_d   = '0;
		end
	end

	// Classification looks at the values as updated by the current byte.
	always_comb begin
		evt.emit   = emit;
		evt.length = clen_q;
		if (seen_d[1:0] != 2'b11) begin
			evt.link = LINK_OTHER;
		end else begin
			case ({eth_hi_d, eth_lo_d})
				ETHERTYPE_IPV4: evt.link = LINK_IPV4;
				ETHERTYPE_ARP:  evt.link = LINK_ARP;
				ETHERTYPE_IPV6: evt.link = LINK_IPV6;
				default:        evt.link = LINK_OTHER;
			endcase
		end
		if (!seen_d[2]) begin
			evt.trans = TRANS_OTHER;
		end else begin
			case (proto_d)
				IPPROTO_TCP:  evt.trans = TRANS_TCP;
				IPPROTO_UDP:  evt.trans = TRANS_UDP;
				IPPROTO_ICMP: evt.trans = TRANS_ICMP;
				IPPROTO_IGMP: evt.trans = TRANS_IGMP;
				default:      evt.trans = TRANS_OTHER;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_GLOBAL;
			pos_q    <= '0;
			clen_q   <= '0;
			eth_hi_q <= '0;
			eth_lo_q <= '0;
			proto_q  <= '0;
			seen_q   <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			clen_q   <= clen_d;
			eth_hi_q <= eth_hi_d;
			eth_lo_q <= eth_lo_d;
			proto_q  <= proto_d;
			seen_q   <= emit ? 3'b000 : seen_d;
		end
	end

endmodule
`default_nettype wire

### hdl/pcap_count.sv
`timescale 1ns / 1ps
`default_nettype none
module pcap_count import pcap_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [1:0]  link,
	input  wire logic [2:0]  trans,
	output logic [31:0]      rec_next,
	output logic [31:0]      link_next,
	output logic [31:0]      trans_next
);

	logic [31:0] rec_q;
	logic [31:0] link_q  [NumLink];
	logic [31:0] trans_q [NumTrans];
	logic [2:0]  trans_idx;

	// Codes above the last class are folded into the other class.
	assign trans_idx = (trans > TRANS_OTHER) ? TRANS_OTHER : trans;

	assign rec_next   = sat_inc(rec_q);
	assign link_next  = sat_inc(link_q[link]);
	assign trans_next = sat_inc(trans_q[trans_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
			for (int i = 0; i < NumLink; i++) begin
				link_q[i] <= '0;
			end
			for (int i = 0; i < NumTrans; i++) begin
				trans_q[i] <= '0;
			end
		end else if (fire) begin
			rec_q            <= rec_next;
			link_q[link]     <= link_next;
			trans_q[trans_idx] <= trans_next;
		end
	end

endmodule
`default_nettype wire

### hdl/pcap_packet_classifier_core.sv
// Classic capture-file classifier.
// The input channel (in_valid, in_stall, data_byte) carries the capture file one
// byte per transaction, starting with the first byte of the global header.
// The output channel (out_valid, out_stall and the result ports) carries one
// transaction per completed record: link class, transport class, record number,
// saturating per-class counts and the captured length of the record.
// A byte is taken into an input register; from there, once it may advance, it
// updates the parser state, the counters and the result register, so out_valid
// rises from the result register after the transaction of the record's last byte.
// One byte is accepted every cycle while in_stall is low; the parser updates
// from each byte with no iteration.
// Reset clears the parser to the start of the global header and all counters
// to zero; nothing is pending afterwards.
// When out_stall holds a waiting result, bytes that complete no record keep
// flowing; a byte that completes a record waits in the input register and
// in_stall rises until the result register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "pcap_packet_classifier_core_defines.svh"
module pcap_packet_classifier_core import pcap_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       link_class,
	output logic [2:0]       trans_class,
	output logic [31:0]      record_number,
	output logic [31:0]      link_class_count,
	output logic [31:0]      trans_class_count,
	output logic [31:0]      record_length
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        advance;
	pcap_evt_t   evt;
	logic [31:0] rec_next, link_next, trans_next;

	logic        out_valid_q;
	logic [1:0]  link_q;
	logic [2:0]  trans_q;
	logic [31:0] rec_q, link_cnt_q, trans_cnt_q, len_q;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!evt.emit || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	pcap_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.data_byte (byte_s1),
		.evt       (evt)
	);

	pcap_count u_count (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance && evt.emit),
		.link       (evt.link),
		.trans      (evt.trans),
		.rec_next   (rec_next),
		.link_next  (link_next),
		.trans_next (trans_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && evt.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && evt.emit) begin
			link_q      <= evt.link;
			trans_q     <= evt.trans;
			rec_q       <= rec_next;
			link_cnt_q  <= link_next;
			trans_cnt_q <= trans_next;
			len_q       <= evt.length;
		end
	end

	assign out_valid         = out_valid_q;
	assign link_class        = link_q;
	assign trans_class       = trans_q;
	assign record_number     = rec_q;
	assign link_class_count  = link_cnt_q;
	assign trans_class_count = trans_cnt_q;
	assign record_length     = len_q;

	`PCAP_ASSERT_IMP(a_load_only_when_free, advance && evt.emit, out_free)
	`PCAP_ASSERT_IMP(a_record_nonzero, out_valid_q, rec_q != 32'd0)
	`PCAP_ASSERT_IMP(a_link_le_record, out_valid_q, link_cnt_q <= rec_q && trans_cnt_q <= rec_q)
	`PCAP_ASSERT_NXT(a_stalled_result_held, out_valid_q && out_stall, out_valid_q && $stable(rec_q))

endmodule
`default_nettype wire
